// ----- hw/rtl/cleb_pkg.sv -----
// Package for the cursor line edit buffer: field widths, command codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package cleb_pkg;

   localparam int CMD_W  = 3;
   localparam int CHAR_W = 8;
   localparam int POS_W  = 10;
   localparam int LEN_W  = 11;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;   // latch the request and start both store reads
      logic commit;    // apply the command and load the result register
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;  // result register is empty or drains this cycle
   } dp_status_type;

endpackage

// ----- hw/rtl/cleb_if.sv -----
// Channel interfaces of the cursor line edit buffer: command beats and result beats.
// Depends on cleb_pkg for the field widths.
interface cleb_req_if;
   logic                         valid;
   logic                         ready;
   logic [cleb_pkg::CMD_W-1:0]   cmd;
   logic [cleb_pkg::CHAR_W-1:0]  char_in;
   logic [cleb_pkg::POS_W-1:0]   read_pos;

   modport source (output valid, cmd, char_in, read_pos, input ready);
   modport sink   (input valid, cmd, char_in, read_pos, output ready);
endinterface

interface cleb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cleb_pkg::CHAR_W-1:0]  char_out;
   logic [cleb_pkg::LEN_W-1:0]   text_length;
   logic [cleb_pkg::LEN_W-1:0]   cursor_pos;
   logic                         ignored;

   modport source (output valid, char_out, text_length, cursor_pos, ignored, input ready);
   modport sink   (input valid, char_out, text_length, cursor_pos, ignored, output ready);
endinterface

// ----- hw/rtl/cleb_ctrl.sv -----
// Controller of the cursor line edit buffer: a two-state sequencer that takes one
// command beat, waits until the result register is free, then commits. Depends on cleb_pkg.
module cleb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cleb_pkg::dp_status_type status,
   output cleb_pkg::ctrl_cmd_type  ctrl
);

   cleb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cleb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.commit  = 1'b0;
      case (state_ff)
         cleb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = cleb_pkg::ST_EXEC;
            end
         end
         cleb_pkg::ST_EXEC: begin
            // Hold here until the result register can take the new result.
            if (status.out_free) begin
               ctrl.commit = 1'b1;
               state_in    = cleb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cleb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/cleb_dp.sv -----
// Datapath of the cursor line edit buffer: the two stack stores, the stack counts,
// the request latch and the result register. Depends on cleb_pkg.
module cleb_dp #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cleb_pkg::ctrl_cmd_type        ctrl,
   output cleb_pkg::dp_status_type       status,
   input  logic [cleb_pkg::CMD_W-1:0]    req_cmd,
   input  logic [cleb_pkg::CHAR_W-1:0]   req_char_in,
   input  logic [cleb_pkg::POS_W-1:0]    req_read_pos,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cleb_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic [cleb_pkg::LEN_W-1:0]    rsp_text_length,
   output logic [cleb_pkg::LEN_W-1:0]    rsp_cursor_pos,
   output logic                          rsp_ignored
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   // Working width for sums and compares; never below the result field width.
   localparam int WW = (CW + 1 > cleb_pkg::LEN_W) ? CW + 1 : cleb_pkg::LEN_W;
   localparam logic [WW-1:0] DEPTH_W = WW'(BUFFER_DEPTH);
   localparam logic [WW-1:0] ONE_W   = WW'(1);

   logic [cleb_pkg::CHAR_W-1:0] left_store_ff  [BUFFER_DEPTH];
   logic [cleb_pkg::CHAR_W-1:0] right_store_ff [BUFFER_DEPTH];
   logic [cleb_pkg::CHAR_W-1:0] left_rd_ff, right_rd_ff;

   logic [CW-1:0] left_count_ff, left_count_in;
   logic [CW-1:0] right_count_ff, right_count_in;

   logic [cleb_pkg::CMD_W-1:0]  cmd_ff;
   logic [cleb_pkg::CHAR_W-1:0] char_ff;
   logic [cleb_pkg::POS_W-1:0]  pos_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cleb_pkg::CHAR_W-1:0] char_out_ff, char_out_in;
   logic [cleb_pkg::LEN_W-1:0]  length_ff, cursor_ff;
   logic                        ignored_ff, ignored_in;

   logic [WW-1:0] lw, rw, tw, req_pw, pw, new_tw, new_lw;
   logic [WW-1:0] left_raddr_w, right_raddr_w;
   logic          left_we, right_we;
   logic [cleb_pkg::CHAR_W-1:0] left_wdata;
   logic [AW-1:0] left_waddr, right_waddr;

   assign lw     = WW'(left_count_ff);
   assign rw     = WW'(right_count_ff);
   assign tw     = lw + rw;
   assign req_pw = WW'(req_read_pos);
   assign pw     = WW'(pos_ff);

   // Read addresses come from the incoming beat and the settled counts.
   always_comb begin
      if (req_cmd == cleb_pkg::CMD_READ) begin
         left_raddr_w  = req_pw;
         right_raddr_w = tw - ONE_W - req_pw;
      end else begin
         left_raddr_w  = lw - ONE_W;
         right_raddr_w = rw - ONE_W;
      end
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_store_ff[left_waddr] <= left_wdata;
      end
      if (ctrl.capture) begin
         left_rd_ff <= left_store_ff[left_raddr_w[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_store_ff[right_waddr] <= left_rd_ff;
      end
      if (ctrl.capture) begin
         right_rd_ff <= right_store_ff[right_raddr_w[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_cmd;
         char_ff <= req_char_in;
         pos_ff  <= req_read_pos;
      end
   end

   assign left_waddr  = left_count_ff[AW-1:0];
   assign right_waddr = right_count_ff[AW-1:0];

   always_comb begin
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      left_we        = 1'b0;
      right_we       = 1'b0;
      left_wdata     = char_ff;
      char_out_in    = '0;
      ignored_in     = 1'b0;
      case (cmd_ff)
         cleb_pkg::CMD_INSERT: begin
            if (tw >= DEPTH_W || lw >= DEPTH_W) begin
               ignored_in = 1'b1;
            end else begin
               left_we       = ctrl.commit;
               left_count_in = left_count_ff + CW'(1);
            end
         end
         cleb_pkg::CMD_LEFT: begin
            if (lw == '0 || rw >= DEPTH_W) begin
               ignored_in = 1'b1;
            end else begin
               right_we       = ctrl.commit;
               left_count_in  = left_count_ff - CW'(1);
               right_count_in = right_count_ff + CW'(1);
            end
         end
         cleb_pkg::CMD_RIGHT: begin
            if (rw == '0 || lw >= DEPTH_W) begin
               ignored_in = 1'b1;
            end else begin
               left_we        = ctrl.commit;
               left_wdata     = right_rd_ff;
               left_count_in  = left_count_ff + CW'(1);
               right_count_in = right_count_ff - CW'(1);
            end
         end
         cleb_pkg::CMD_BACK: begin
            if (lw == '0) begin
               ignored_in = 1'b1;
            end else begin
               left_count_in = left_count_ff - CW'(1);
            end
         end
         cleb_pkg::CMD_READ: begin
            if (pw < lw) begin
               char_out_in = left_rd_ff;
            end else if (pw < tw) begin
               char_out_in = right_rd_ff;
            end else begin
               ignored_in = 1'b1;
            end
         end
         default: begin
            ignored_in = 1'b1;
         end
      endcase
   end

   assign new_lw = WW'(left_count_in);
   assign new_tw = new_lw + WW'(right_count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else if (ctrl.commit) begin
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         char_out_ff <= char_out_in;
         length_ff   <= new_tw[cleb_pkg::LEN_W-1:0];
         cursor_ff   <= new_lw[cleb_pkg::LEN_W-1:0];
         ignored_ff  <= ignored_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = char_out_ff;
   assign rsp_text_length = length_ff;
   assign rsp_cursor_pos  = cursor_ff;
   assign rsp_ignored     = ignored_ff;

   // The two stacks together never hold more than the buffer depth.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      tw <= DEPTH_W)
      else $error("stack counts exceed buffer depth");

   // A commit always leaves a result waiting.
   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_valid_ff)
      else $error("commit did not load the result register");

   // Counts move only when a command commits.
   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.commit |=> $stable(left_count_ff) && $stable(right_count_ff))
      else $error("stack counts changed without a commit");

endmodule

// ----- hw/rtl/cursor_line_edit_buffer_top.sv -----
// Top level of the cursor line edit buffer (two-stack gap buffer line editor).
// Depends on cleb_pkg, cleb_if, cleb_ctrl and cleb_dp.
//
//   channel   direction  beat carries
//   req_chan  in         cmd, char_in, read_pos
//   rsp_chan  out        char_out, text_length, cursor_pos, ignored
//
// Each command has a capture step that latches the beat and reads both stores (registered
// read port), then a commit step that writes the other stack and updates the counts.
// A result waits in an output register; while it is not taken the commit stalls.
// Reset clears the stack counts, the result valid and the controller state; store contents stay undefined.
// One result beat per command beat, in order.
module cursor_line_edit_buffer_top #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   cleb_req_if.sink    req_chan,
   cleb_rsp_if.source  rsp_chan
);

   cleb_pkg::ctrl_cmd_type  ctrl;
   cleb_pkg::dp_status_type status;

   cleb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   cleb_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_cmd         (req_chan.cmd),
      .req_char_in     (req_chan.char_in),
      .req_read_pos    (req_chan.read_pos),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_char_out    (rsp_chan.char_out),
      .rsp_text_length (rsp_chan.text_length),
      .rsp_cursor_pos  (rsp_chan.cursor_pos),
      .rsp_ignored     (rsp_chan.ignored)
   );

endmodule

// ----- verif/tb.sv -----
// Testbench for cursor_line_edit_buffer_top: drives editing commands, predicts every result
// with its own two-stack text model and checks every field of each result beat.
// Depends on cleb_pkg, the cleb_req_if/cleb_rsp_if interfaces and the RTL of the block.
module tb;

   localparam int CMD_W  = cleb_pkg::CMD_W;
   localparam int CHAR_W = cleb_pkg::CHAR_W;
   localparam int POS_W  = cleb_pkg::POS_W;
   localparam int LEN_W  = cleb_pkg::LEN_W;

   localparam int BUFFER_DEPTH = 1024;
   localparam int MAX_POS      = 2**POS_W - 1;
   localparam int MAX_CHAR     = 2**CHAR_W - 1;
   localparam int MAX_CMD      = 2**CMD_W - 1;
   localparam int PHASE_ITEMS  = 270;
   localparam int TAIL_ITEMS   = 30;
   localparam int STUCK_LIMIT  = 5000;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
      logic [POS_W-1:0]  pos;
      logic              drain_first;
      logic [1:0]        phase;
   } edit_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic [LEN_W-1:0]  text_length;
      logic [LEN_W-1:0]  cursor_pos;
      logic              ignored;
   } edit_result_type;

   logic clock;
   logic reset;

   cleb_req_if req_if ();
   cleb_rsp_if rsp_if ();

   cursor_line_edit_buffer_top #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Idle and stall percentages for the four traffic phases.
   int sender_idle_pct    [4] = '{0, 50, 0, 26};
   int receiver_stall_pct [4] = '{0, 0, 50, 26};

   edit_item_type   pending_edits [$];
   edit_result_type expected_results [$];

   // Predicted text: characters left of the cursor bottom first, and
   // characters right of the cursor in reverse order.
   logic [CHAR_W-1:0] left_text      [BUFFER_DEPTH];
   logic [CHAR_W-1:0] right_text_rev [BUFFER_DEPTH];
   int unsigned       left_len;
   int unsigned       right_len;

   // Length and cursor tally used only to shape the stimulus.
   int   plan_len;
   int   plan_cur;
   int   random_count;
   logic [1:0] plan_phase;

   logic [1:0] cur_phase;
   logic       req_fired;
   int         fail_count;
   int         stuck_cycles;

   function automatic edit_result_type apply_edit(edit_item_type e);
      edit_result_type r;
      int unsigned     total;
      total = left_len + right_len;
      r = '0;
      case (e.cmd)
         cleb_pkg::CMD_INSERT: begin
            if (total >= BUFFER_DEPTH) begin
               r.ignored = 1'b1;
            end else begin
               left_text[left_len] = e.ch;
               left_len++;
            end
         end
         cleb_pkg::CMD_LEFT: begin
            if (left_len == 0) begin
               r.ignored = 1'b1;
            end else begin
               left_len--;
               right_text_rev[right_len] = left_text[left_len];
               right_len++;
            end
         end
         cleb_pkg::CMD_RIGHT: begin
            if (right_len == 0) begin
               r.ignored = 1'b1;
            end else begin
               right_len--;
               left_text[left_len] = right_text_rev[right_len];
               left_len++;
            end
         end
         cleb_pkg::CMD_BACK: begin
            if (left_len == 0) r.ignored = 1'b1;
            else left_len--;
         end
         cleb_pkg::CMD_READ: begin
            if (e.pos < left_len) begin
               r.char_out = left_text[e.pos];
            end else if (e.pos < total) begin
               r.char_out = right_text_rev[right_len - 1 - (e.pos - left_len)];
            end else begin
               r.ignored = 1'b1;
            end
         end
         default: r.ignored = 1'b1;
      endcase
      r.text_length = LEN_W'(left_len + right_len);
      r.cursor_pos  = LEN_W'(left_len);
      return r;
   endfunction

   task automatic queue_edit(logic [CMD_W-1:0] cmd, int ch, int pos, logic drain_first);
      edit_item_type e;
      e.cmd         = cmd;
      e.ch          = CHAR_W'(ch);
      e.pos         = POS_W'(pos);
      e.drain_first = drain_first;
      e.phase       = plan_phase;
      pending_edits.push_back(e);
      case (cmd)
         cleb_pkg::CMD_INSERT: if (plan_len < BUFFER_DEPTH) begin
            plan_len++;
            plan_cur++;
         end
         cleb_pkg::CMD_LEFT:  if (plan_cur > 0) plan_cur--;
         cleb_pkg::CMD_RIGHT: if (plan_cur < plan_len) plan_cur++;
         cleb_pkg::CMD_BACK:  if (plan_cur > 0) begin
            plan_cur--;
            plan_len--;
         end
         default: ;
      endcase
   endtask

   // While filling, inserts dominate so the buffer reaches full; afterwards the mix spreads over
   // all commands and undefined codes, and inserts bounce off the full buffer unless a backspace freed room.
   task automatic queue_random_edit(bit filling);
      int roll;
      int pos;
      logic [CMD_W-1:0] cmd;
      plan_phase = 2'((random_count / PHASE_ITEMS) % 4);
      roll = $urandom_range(99);
      if (filling) begin
         if (roll < 97)      cmd = cleb_pkg::CMD_INSERT;
         else if (roll < 98) cmd = cleb_pkg::CMD_LEFT;
         else if (roll < 99) cmd = cleb_pkg::CMD_RIGHT;
         else                cmd = cleb_pkg::CMD_READ;
      end else begin
         if (roll < 25)      cmd = cleb_pkg::CMD_INSERT;
         else if (roll < 45) cmd = cleb_pkg::CMD_LEFT;
         else if (roll < 65) cmd = cleb_pkg::CMD_RIGHT;
         else if (roll < 78) cmd = cleb_pkg::CMD_BACK;
         else if (roll < 97) cmd = cleb_pkg::CMD_READ;
         else                cmd = CMD_W'($urandom_range(MAX_CMD, cleb_pkg::CMD_READ + 1));
      end
      if (plan_len == 0 || $urandom_range(9) == 0) pos = $urandom_range(MAX_POS);
      else pos = $urandom_range(plan_len - 1);
      queue_edit(cmd, $urandom_range(MAX_CHAR), pos, random_count == 0);
      random_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : stimulus
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.cmd       = cleb_pkg::CMD_INSERT;
      req_if.char_in   = '0;
      req_if.read_pos  = '0;
      rsp_if.ready     = 1'b0;
      plan_len     = 0;
      plan_cur     = 0;
      random_count = 0;
      plan_phase   = 2'd0;

      // Boundaries of the empty buffer and undefined codes, then a short text read through both stacks.
      queue_edit(cleb_pkg::CMD_LEFT, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_RIGHT, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_BACK, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_READ, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_READ, 0, MAX_POS, 1'b0);
      for (int k = cleb_pkg::CMD_READ + 1; k <= MAX_CMD; k++)
         queue_edit(CMD_W'(k), $urandom_range(MAX_CHAR), $urandom_range(MAX_POS), 1'b0);
      queue_edit(cleb_pkg::CMD_INSERT, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_INSERT, MAX_CHAR, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_INSERT, 'h55, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_INSERT, 'hAA, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_LEFT, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_LEFT, 0, 0, 1'b0);
      for (int p = 0; p <= 4; p++) queue_edit(cleb_pkg::CMD_READ, 0, p, 1'b0);
      queue_edit(cleb_pkg::CMD_RIGHT, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_BACK, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_RIGHT, 0, 0, 1'b0);
      queue_edit(cleb_pkg::CMD_RIGHT, 0, 0, 1'b0);

      while (plan_len < BUFFER_DEPTH) queue_random_edit(1'b1);
      queue_edit(cleb_pkg::CMD_INSERT, $urandom_range(MAX_CHAR), 0, 1'b1);
      queue_edit(cleb_pkg::CMD_READ, 0, MAX_POS, 1'b0);
      queue_edit(cleb_pkg::CMD_READ, 0, 0, 1'b0);
      repeat (TAIL_ITEMS) queue_random_edit(1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_edits.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

   // Command driver: a held beat stays until taken; a new one may wait for an
   // idle cycle or, when flagged, until all outstanding results are back.
   always @(negedge clock) begin : drive_req
      edit_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
         cur_phase    <= 2'd0;
      end else begin
         if (!req_if.valid || req_fired) begin
            if (pending_edits.size() != 0
                && !(pending_edits[0].drain_first && expected_results.size() != 0)
                && $urandom_range(99) >= sender_idle_pct[cur_phase]) begin
               nxt = pending_edits.pop_front();
               req_if.valid    <= 1'b1;
               req_if.cmd      <= nxt.cmd;
               req_if.char_in  <= nxt.ch;
               req_if.read_pos <= nxt.pos;
               cur_phase       <= nxt.phase;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct[cur_phase]);
      end
   end

   always @(posedge clock) begin : check_rsp
      edit_item_type   taken;
      edit_result_type got;
      edit_result_type want;
      if (reset) begin
         req_fired    <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            taken = '0;
            taken.cmd = req_if.cmd;
            taken.ch  = req_if.char_in;
            taken.pos = req_if.read_pos;
            expected_results.push_back(apply_edit(taken));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.char_out    = rsp_if.char_out;
            got.text_length = rsp_if.text_length;
            got.cursor_pos  = rsp_if.cursor_pos;
            got.ignored     = rsp_if.ignored;
            if (expected_results.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("unexpected result beat: char %h len %0d cursor %0d ignored %b",
                           got.char_out, got.text_length, got.cursor_pos, got.ignored);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"mismatch: expected char %h len %0d cursor %0d ignored %b,",
                               " got char %h len %0d cursor %0d ignored %b"},
                              want.char_out, want.text_length, want.cursor_pos, want.ignored,
                              got.char_out, got.text_length, got.cursor_pos, got.ignored);
                  fail_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb failed");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- cursor_line_edit_buffer_top.f -----
hw/rtl/cleb_pkg.sv
hw/rtl/cleb_if.sv
hw/rtl/cleb_ctrl.sv
hw/rtl/cleb_dp.sv
hw/rtl/cursor_line_edit_buffer_top.sv
verif/tb.sv
